>>> design/census_pkg.sv
// Shared types and constants of the 5x5 census transform core.
`timescale 1ns / 1ps
`default_nettype none

package census_pkg;

  localparam int PIXEL_W     = 8;
  localparam int CODE_W      = 24;
  localparam int IMG_W_BITS  = 12;
  localparam int IMG_H_BITS  = 13;
  localparam int ROW_CNT_W   = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int WIDTH_MIN   = 16;
  localparam int WIDTH_RST   = 640;
  localparam int HEIGHT_MIN  = 6;
  localparam int HEIGHT_MAX  = 4096;
  localparam int HEIGHT_RST  = 480;
  localparam int WIN_ROWS    = 5;
  localparam int WIN_COLS    = 5;
  localparam int MEM_ROWS    = 4;
  localparam int REFILL_COLS = 4;
  localparam int FILL_COL_W  = 2;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    FILL_IDLE = 1'b0,
    FILL_RUN  = 1'b1
  } fill_state_t;

  // Read-stage control handed from the sequencer to the window.
  typedef struct packed {
    logic                  item;
    logic                  emit;
    logic                  last;
    logic                  fill_wr;
    logic [FILL_COL_W-1:0] fill_col;
    logic [MEM_ROWS-1:0]   row_zero;
    pixel_t                pixel;
  } win_ctl_t;

endpackage

`default_nettype wire

>>> design/census_dpram.sv
// Delay-line memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module census_dpram #(
  parameter int DEPTH  = 8197,
  parameter int ADDR_W = 14,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr_a,
  input  wire logic [ADDR_W-1:0] rd_addr_b,
  output logic      [DATA_W-1:0] rd_data_a,
  output logic      [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem_r[rd_addr_a];
      rd_data_b <= mem_r[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

>>> design/census_ctrl.sv
// Configuration, raster counters, delay-line pointers and window reload sequencer.
`timescale 1ns / 1ps
`default_nettype none

module census_ctrl #(
  parameter int MAX_WIDTH = 2048,
  parameter int DEPTH     = 8197,
  parameter int ADDR_W    = 14
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        cfg_wr_en,
  input  wire logic [census_pkg::CFG_IDX_W-1:0]            cfg_idx,
  input  wire logic [census_pkg::CFG_DATA_W-1:0]           cfg_wdata,
  input  wire logic                                        in_tvalid,
  output logic                                             in_tready,
  input  wire logic [census_pkg::PIXEL_W-1:0]              in_tdata,
  input  wire logic                                        advance,
  output logic                                             ram_wr_en,
  output logic      [ADDR_W-1:0]                           ram_wr_addr,
  output logic                                             ram_rd_en,
  output logic      [census_pkg::MEM_ROWS-1:0][ADDR_W-1:0] ram_rd_addr,
  output census_pkg::win_ctl_t                             ctl_r
);

  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int WCMP_W  = (WW > census_pkg::IMG_W_BITS) ? WW : census_pkg::IMG_W_BITS;
  localparam int HW      = census_pkg::IMG_H_BITS;
  localparam int RW      = census_pkg::ROW_CNT_W;
  localparam int NR      = census_pkg::MEM_ROWS;
  localparam int KW      = census_pkg::FILL_COL_W;
  localparam int W_RST   = (census_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                               : census_pkg::WIDTH_RST;

  logic [WW-1:0]      w_r;
  logic [HW-1:0]      h_r;
  logic [ADDR_W-1:0]  age_r [NR];
  logic [ADDR_W-1:0]  age_nxt [NR];
  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [ADDR_W-1:0]  wp_r, wp_nxt;
  logic [ADDR_W-1:0]  fill_r, fill_nxt;
  logic [ADDR_W-1:0]  fbase_r, fbase_nxt;
  logic [ADDR_W-1:0]  favail_r, favail_nxt;
  logic [KW-1:0]      fk_r, fk_nxt;
  census_pkg::fill_state_t fst_r, fst_nxt;
  census_pkg::win_ctl_t    ctl_nxt;

  logic               width_wr, height_wr;
  logic [WCMP_W-1:0]  w_in;
  logic [WW-1:0]      w_sat;
  logic [HW-1:0]      h_in, h_sat;
  logic               accept, fill_issue;
  logic               col_ge2, emit_c, last_c, col_wrap, row_wrap;
  logic [HW-1:0]      row_x, h_m1, h_m2, row_inc;
  logic [WW:0]        col_inc, col_x, w_p1;
  logic [ADDR_W-1:0]  rd_base, rd_avail;
  logic [ADDR_W:0]    diff [NR];
  logic [NR-1:0]      zero_c;

  // config decode, saturation and line-age offsets
  always_comb begin
    width_wr  = cfg_wr_en && (cfg_idx == census_pkg::CFG_WIDTH);
    height_wr = cfg_wr_en && (cfg_idx == census_pkg::CFG_HEIGHT);
    w_in = WCMP_W'(cfg_wdata[census_pkg::IMG_W_BITS-1:0]);
    if (w_in < WCMP_W'(census_pkg::WIDTH_MIN)) begin
      w_sat = WW'(census_pkg::WIDTH_MIN);
    end else if (w_in > WCMP_W'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(w_in);
    end
    h_in = cfg_wdata[HW-1:0];
    if (h_in < HW'(census_pkg::HEIGHT_MIN)) begin
      h_sat = HW'(census_pkg::HEIGHT_MIN);
    end else if (h_in > HW'(census_pkg::HEIGHT_MAX)) begin
      h_sat = HW'(census_pkg::HEIGHT_MAX);
    end else begin
      h_sat = h_in;
    end
    for (int r = 0; r < NR; r++) begin
      age_nxt[r] = ADDR_W'(ADDR_W'(w_sat) * ADDR_W'(r + 1));
    end
  end

  // reload sequencer
  always_comb begin
    fst_nxt = fst_r;
    fk_nxt  = fk_r;
    case (fst_r)
      census_pkg::FILL_IDLE: begin
      end
      census_pkg::FILL_RUN: begin
        if (advance) begin
          fk_nxt = fk_r + KW'(1);
          if (fk_r == KW'(census_pkg::REFILL_COLS - 1)) begin
            fst_nxt = census_pkg::FILL_IDLE;
          end
        end
      end
      default: begin
        fst_nxt = census_pkg::FILL_IDLE;
      end
    endcase
    if (width_wr) begin
      fst_nxt = census_pkg::FILL_RUN;
      fk_nxt  = '0;
    end
  end

  assign fill_issue = (fst_r == census_pkg::FILL_RUN) && advance;
  assign in_tready  = advance && (fst_r == census_pkg::FILL_IDLE);
  assign accept     = in_tvalid && in_tready;

  // raster position, emit and last flags, write pointer and fill count
  always_comb begin
    col_ge2 = col_r >= CW'(2);
    row_x   = HW'(row_r);
    h_m1    = h_r - HW'(1);
    h_m2    = h_r - HW'(2);
    col_x   = (WW + 1)'(col_r);
    w_p1    = (WW + 1)'(w_r) + (WW + 1)'(1);
    if (col_ge2) begin
      emit_c = (row_r >= RW'(4)) && (row_x <= h_m2);
      last_c = (row_x == h_m2) && (col_x == w_p1);
    end else begin
      emit_c = (row_r >= RW'(5)) && (row_x <= h_m1);
      last_c = (row_x == h_m1) && (col_r == CW'(1));
    end
    col_inc  = (WW + 1)'(col_r) + (WW + 1)'(1);
    col_wrap = col_inc >= (WW + 1)'(w_r);
    row_inc  = row_x + HW'(1);
    row_wrap = row_inc >= h_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
      wp_nxt   = (wp_r == ADDR_W'(DEPTH - 1)) ? '0 : wp_r + ADDR_W'(1);
      fill_nxt = (fill_r == ADDR_W'(DEPTH - 1)) ? fill_r : fill_r + ADDR_W'(1);
    end
  end

  // reload base walks back from the last written pixel
  always_comb begin
    fbase_nxt  = fbase_r;
    favail_nxt = favail_r;
    if (width_wr) begin
      fbase_nxt  = (wp_r == '0) ? ADDR_W'(DEPTH - 1) : wp_r - ADDR_W'(1);
      favail_nxt = (fill_r == '0) ? '0 : fill_r - ADDR_W'(1);
    end else if (fill_issue) begin
      fbase_nxt  = (fbase_r == '0) ? ADDR_W'(DEPTH - 1) : fbase_r - ADDR_W'(1);
      favail_nxt = (favail_r == '0) ? '0 : favail_r - ADDR_W'(1);
    end
  end

  // row read addresses; ages beyond the pixels written so far read as zero
  always_comb begin
    rd_base  = (fst_r == census_pkg::FILL_RUN) ? fbase_r : wp_r;
    rd_avail = (fst_r == census_pkg::FILL_RUN) ? favail_r : fill_r;
    for (int r = 0; r < NR; r++) begin
      diff[r] = {1'b0, rd_base} - {1'b0, age_r[r]};
      if (diff[r][ADDR_W]) begin
        ram_rd_addr[r] = ADDR_W'(diff[r] + (ADDR_W + 1)'(DEPTH));
      end else begin
        ram_rd_addr[r] = diff[r][ADDR_W-1:0];
      end
      zero_c[r] = age_r[r] > rd_avail;
    end
  end

  assign ram_rd_en   = accept || fill_issue;
  assign ram_wr_en   = accept;
  assign ram_wr_addr = wp_r;

  always_comb begin
    ctl_nxt          = ctl_r;
    ctl_nxt.item     = accept;
    ctl_nxt.emit     = emit_c;
    ctl_nxt.last     = last_c;
    ctl_nxt.fill_wr  = fill_issue;
    ctl_nxt.fill_col = fk_r;
    ctl_nxt.row_zero = zero_c;
    ctl_nxt.pixel    = in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= census_pkg::FILL_IDLE;
      fk_r  <= '0;
    end else begin
      fst_r <= fst_nxt;
      fk_r  <= fk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= WW'(W_RST);
      h_r      <= HW'(census_pkg::HEIGHT_RST);
      col_r    <= '0;
      row_r    <= '0;
      wp_r     <= '0;
      fill_r   <= '0;
      fbase_r  <= '0;
      favail_r <= '0;
      ctl_r    <= '0;
      for (int r = 0; r < NR; r++) begin
        age_r[r] <= ADDR_W'(W_RST * (r + 1));
      end
    end else begin
      if (width_wr) begin
        w_r <= w_sat;
        for (int r = 0; r < NR; r++) begin
          age_r[r] <= age_nxt[r];
        end
      end
      if (height_wr) begin
        h_r <= h_sat;
      end
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      fbase_r  <= fbase_nxt;
      favail_r <= favail_nxt;
      if (advance) begin
        ctl_r <= ctl_nxt;
      end
    end
  end

  a_fill_tracks_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != ADDR_W'(DEPTH - 1)) |-> (wp_r == fill_r))
    else $error("fill count and write pointer diverged");

  a_no_accept_in_reload: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && fill_issue))
    else $error("word accepted during window reload");

  a_ctl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.fill_wr |-> !ctl_r.item)
    else $error("reload write and pixel word in the same read stage");

endmodule

`default_nettype wire

>>> design/census_window.sv
// 5x5 window registers, census comparisons and output register.
`timescale 1ns / 1ps
`default_nettype none

module census_window (
  input  wire logic                                                 clk,
  input  wire logic                                                 rst_n,
  input  wire census_pkg::win_ctl_t                                 ctl,
  input  wire logic [census_pkg::MEM_ROWS-1:0][census_pkg::PIXEL_W-1:0] rd_row,
  output logic                                                      advance,
  output logic                                                      out_tvalid,
  input  wire logic                                                 out_tready,
  output logic      [census_pkg::CODE_W-1:0]                        out_tdata,
  output logic                                                      out_tlast
);

  localparam int NR = census_pkg::WIN_ROWS;
  localparam int NC = census_pkg::WIN_COLS;

  census_pkg::pixel_t win_r [NR][NC];
  census_pkg::pixel_t row_new [NR];
  logic                          s2_emit_r, s2_last_r;
  logic                          out_valid_r, out_last_r;
  logic [census_pkg::CODE_W-1:0] out_code_r, code_c;
  logic                          out_load_ok;

  assign out_load_ok = !out_valid_r || out_tready;
  assign advance     = !s2_emit_r || out_load_ok;

  always_comb begin
    row_new[0] = ctl.pixel;
    for (int r = 1; r < NR; r++) begin
      row_new[r] = ctl.row_zero[r-1] ? '0 : rd_row[r-1];
    end
  end

  // column-major bit order, column offset outer, center skipped;
  // win_r[r][c] holds the pixel r lines plus c pixels older than the newest
  for (genvar gc = 0; gc < NC; gc++) begin : g_col
    for (genvar gr = 0; gr < NR; gr++) begin : g_row
      localparam int POS = gc * NR + gr;
      localparam int CTR = (NC * NR) / 2;
      if (POS != CTR) begin : g_bit
        localparam int BIT = (POS < CTR) ? POS : POS - 1;
        assign code_c[BIT] = win_r[NR-1-gr][NC-1-gc] > win_r[NR/2][NC/2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_emit_r   <= 1'b0;
      s2_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < NR; r++) begin
        for (int c = 0; c < NC; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (advance) begin
        s2_emit_r <= ctl.item && ctl.emit;
        s2_last_r <= ctl.last;
        if (ctl.item) begin
          for (int r = 0; r < NR; r++) begin
            for (int c = NC - 1; c > 0; c--) begin
              win_r[r][c] <= win_r[r][c-1];
            end
            win_r[r][0] <= row_new[r];
          end
        end
      end
      if (ctl.fill_wr) begin
        for (int r = 1; r < NR; r++) begin
          for (int c = 0; c < census_pkg::REFILL_COLS; c++) begin
            if (ctl.fill_col == census_pkg::FILL_COL_W'(c)) begin
              win_r[r][c] <= row_new[r];
            end
          end
        end
      end
      if (out_load_ok) begin
        out_valid_r <= s2_emit_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_ok && s2_emit_r) begin
      out_code_r <= code_c;
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_code_r;
  assign out_tlast  = out_last_r;

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_emit_r))
    else $error("output word without an emitting window");

endmodule

`default_nettype wire

>>> design/census_transform_5x5_core.sv
// Top level of the streaming 5x5 census transform.
`timescale 1ns / 1ps
`default_nettype none

// Takes one 8-bit pixel word per cycle in raster order, unless the output
// stalls or a reload runs, and returns one 24-bit census code per center pixel
// of rows 2 through image_height-4, with tlast on the frame's last code. A code
// passes the read stage and window registers into the output register after the
// pixel completing its window. The pixel history sits in two copies of a
// 4*MAX_WIDTH+5 byte delay memory, each read at two line offsets per cycle; a
// 5x5 register window shifts along them. After reset the history reads as zero
// through a fill count, so there is no clearing pass. Writing image_width
// reloads four window columns from the delay memory, with in_tready low.
module census_transform_5x5_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [census_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [census_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [census_pkg::PIXEL_W-1:0]       in_tdata,   // [7:0] pixel
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [census_pkg::CODE_W-1:0]        out_tdata,  // [23:0] census_code
  output logic                                      out_tlast   // frame_last
);

  localparam int DEPTH  = 4 * MAX_WIDTH + 5;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NR     = census_pkg::MEM_ROWS;

  census_pkg::win_ctl_t                         ctl;
  logic                                         advance;
  logic                                         ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0]                            ram_wr_addr;
  logic [NR-1:0][ADDR_W-1:0]                    ram_rd_addr;
  logic [NR-1:0][census_pkg::PIXEL_W-1:0]       rd_row;

  census_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .advance     (advance),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ctl_r       (ctl)
  );

  census_dpram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (census_pkg::PIXEL_W)
  ) u_mem_lo (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (in_tdata),
    .rd_en     (ram_rd_en),
    .rd_addr_a (ram_rd_addr[0]),
    .rd_addr_b (ram_rd_addr[1]),
    .rd_data_a (rd_row[0]),
    .rd_data_b (rd_row[1])
  );

  census_dpram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (census_pkg::PIXEL_W)
  ) u_mem_hi (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (in_tdata),
    .rd_en     (ram_rd_en),
    .rd_addr_a (ram_rd_addr[2]),
    .rd_addr_b (ram_rd_addr[3]),
    .rd_data_a (rd_row[2]),
    .rd_data_b (rd_row[3])
  );

  census_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rd_row     (rd_row),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
